FILE: rtl/rmcd_pkg.sv
package rmcd_pkg;

	localparam int NUM_W  = 24;
	localparam int GEN_W  = 16;
	localparam int KEY_W  = NUM_W + GEN_W;
	localparam int SOFT_W = 5;

	localparam logic [SOFT_W-1:0] SOFT_LIMIT_RST = 5'd8;

	localparam logic [1:0] OP_LOOKUP  = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_CLEAR   = 2'd2;

	localparam logic [2:0] STAT_HIT         = 3'd0;
	localparam logic [2:0] STAT_INSERTED    = 3'd1;
	localparam logic [2:0] STAT_CREATE_FAIL = 3'd2;
	localparam logic [2:0] STAT_FULL        = 3'd3;
	localparam logic [2:0] STAT_RELEASED    = 3'd4;
	localparam logic [2:0] STAT_REL_MISS    = 3'd5;
	localparam logic [2:0] STAT_CLEARED     = 3'd6;

	typedef struct packed {
		logic [1:0]       op;
		logic [NUM_W-1:0] obj_num;
		logic [GEN_W-1:0] obj_gen;
		logic             create_ok;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  hit_position;
		logic [15:0] ref_count;
		logic [4:0]  evicted;
		logic [4:0]  occupancy;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_EVICT_RD,
		ST_EVICT_CHK,
		ST_PLACE,
		ST_SHIFT,
		ST_WRITE,
		ST_DONE
	} state_t;

endpackage

FILE: rtl/refcounted_mru_cache_directory_top.sv
// After acceptance a lookup or release searches for its key, while a clear just empties the
// directory. A lookup miss then reads and checks tail entries for eviction and tries to place
// the new entry; a lookup that hits or inserts shifts entries down and writes the front entry,
// a release hit rewrites its entry in place, and each result is handed to the output register.
// Throughput is one transaction at a time; the next is taken once the result is registered.
// Reset empties the directory and sets soft_limit to 8; no clearing pass is needed.
module refcounted_mru_cache_directory_top #(
	parameter int CAPACITY = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  rmcd_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output rmcd_pkg::rsp_t              rsp,
	input  logic                        cfg_we,
	input  logic [rmcd_pkg::SOFT_W-1:0] cfg_wdata
);

	localparam int AW = $clog2(CAPACITY);
	localparam int DW = rmcd_pkg::KEY_W + COUNT_BITS;

	logic [rmcd_pkg::SOFT_W-1:0] soft_limit_q;
	logic                        rsp_valid_q;
	rmcd_pkg::rsp_t              rsp_q;

	logic           start;
	logic           res_valid;
	logic           res_take;
	rmcd_pkg::rsp_t res;
	logic           rd_en;
	logic [AW-1:0]  rd_addr;
	logic [DW-1:0]  rd_data;
	logic           wr_en;
	logic [AW-1:0]  wr_addr;
	logic [DW-1:0]  wr_data;

	assign start     = req_valid && req_ready;
	assign res_take  = res_valid && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			soft_limit_q <= rmcd_pkg::SOFT_LIMIT_RST;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				soft_limit_q <= cfg_wdata;
			end
			if (res_take) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	rmcd_ctrl #(
		.CAPACITY   (CAPACITY),
		.COUNT_BITS (COUNT_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.item       (req),
		.soft_limit (soft_limit_q),
		.ready      (req_ready),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res        (res),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data)
	);

	rmcd_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (DW)
	) u_mem (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data_q (rd_data)
	);

endmodule

FILE: rtl/rmcd_mem.sv
module rmcd_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 56,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

endmodule

FILE: rtl/rmcd_ctrl.sv
module rmcd_ctrl #(
	parameter int CAPACITY = 16,
	parameter int COUNT_BITS = 16,
	localparam int AW = $clog2(CAPACITY),
	localparam int OW = $clog2(CAPACITY + 1),
	localparam int DW = rmcd_pkg::KEY_W + COUNT_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  rmcd_pkg::req_t              item,
	input  logic [rmcd_pkg::SOFT_W-1:0] soft_limit,
	output logic                        ready,
	output logic                        res_valid,
	input  logic                        res_take,
	output rmcd_pkg::rsp_t              res,
	output logic                        rd_en,
	output logic [AW-1:0]               rd_addr,
	input  logic [DW-1:0]               rd_data,
	output logic                        wr_en,
	output logic [AW-1:0]               wr_addr,
	output logic [DW-1:0]               wr_data
);

	localparam int CW = COUNT_BITS;
	localparam int CMPW = (OW > rmcd_pkg::SOFT_W) ? OW : rmcd_pkg::SOFT_W;
	localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
	localparam logic [CW-1:0] CNT_ONE = CW'(1);
	localparam logic [CW-1:0] CNT_ZERO = '0;
	localparam logic [OW-1:0] OCC_FULL = OW'(CAPACITY);
	localparam logic [OW-1:0] OW_ONE = OW'(1);

	rmcd_pkg::state_t state_q, state_d;
	logic [OW-1:0] occ_q, occ_d;
	logic [OW-1:0] idx_q, idx_d;
	logic [OW-1:0] evict_q, evict_d;
	logic          pend_q, pend_d;

	rmcd_pkg::req_t item_q, item_d;
	logic [2:0]     status_q, status_d;
	logic [AW-1:0]  pos_q, pos_d;
	logic [CW-1:0]  cnt_q, cnt_d;
	logic [AW-1:0]  wpos_q, wpos_d;
	logic [AW-1:0]  wdst_q, wdst_d;

	logic [OW-1:0]   idx_m1;
	logic [OW-1:0]   occ_m1;
	logic [CW-1:0]   rd_cnt;
	logic            key_match;
	logic            evict_ok;
	logic [CMPW-1:0] occ_cmp;
	logic [CMPW-1:0] soft_cmp;

	logic [AW+3:0]  pos_wide;
	logic [CW+15:0] cnt_wide;
	logic [OW+4:0]  evict_wide;
	logic [OW+4:0]  occ_wide;

	assign idx_m1    = idx_q - OW_ONE;
	assign occ_m1    = occ_q - OW_ONE;
	assign rd_cnt    = rd_data[CW-1:0];
	assign key_match = rd_data[DW-1:CW] == {item_q.obj_num, item_q.obj_gen};
	assign occ_cmp   = CMPW'(occ_q);
	assign soft_cmp  = CMPW'(soft_limit);
	assign evict_ok  = (occ_q != '0) && (occ_cmp >= soft_cmp);

	assign pos_wide   = {4'b0, pos_q};
	assign cnt_wide   = {16'b0, cnt_q};
	assign evict_wide = {5'b0, evict_q};
	assign occ_wide   = {5'b0, occ_q};

	always_comb begin
		res.status       = status_q;
		res.hit_position = pos_wide[3:0];
		res.ref_count    = cnt_wide[15:0];
		res.evicted      = evict_wide[4:0];
		res.occupancy    = occ_wide[4:0];
	end

	always_comb begin
		state_d   = state_q;
		occ_d     = occ_q;
		idx_d     = idx_q;
		evict_d   = evict_q;
		pend_d    = pend_q;
		item_d    = item_q;
		status_d  = status_q;
		pos_d     = pos_q;
		cnt_d     = cnt_q;
		wpos_d    = wpos_q;
		wdst_d    = wdst_q;
		ready     = 1'b0;
		res_valid = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = wpos_q;
		wr_data   = {item_q.obj_num, item_q.obj_gen, cnt_q};

		unique case (state_q)
			rmcd_pkg::ST_IDLE: begin
				ready = 1'b1;
				if (start) begin
					item_d  = item;
					pos_d   = '0;
					cnt_d   = CNT_ZERO;
					evict_d = '0;
					idx_d   = '0;
					pend_d  = 1'b0;
					if (item.op == rmcd_pkg::OP_LOOKUP || item.op == rmcd_pkg::OP_RELEASE) begin
						state_d = rmcd_pkg::ST_SEARCH;
					end else begin
						occ_d    = '0;
						status_d = rmcd_pkg::STAT_CLEARED;
						state_d  = rmcd_pkg::ST_DONE;
					end
				end
			end
			rmcd_pkg::ST_SEARCH: begin
				if (pend_q && key_match) begin
					pos_d  = idx_m1[AW-1:0];
					pend_d = 1'b0;
					if (item_q.op == rmcd_pkg::OP_LOOKUP) begin
						cnt_d    = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + CNT_ONE;
						status_d = rmcd_pkg::STAT_HIT;
						idx_d    = idx_m1;
						wpos_d   = '0;
						state_d  = rmcd_pkg::ST_SHIFT;
					end else begin
						cnt_d    = (rd_cnt == CNT_ZERO) ? CNT_ZERO : rd_cnt - CNT_ONE;
						status_d = rmcd_pkg::STAT_RELEASED;
						wpos_d   = idx_m1[AW-1:0];
						state_d  = rmcd_pkg::ST_WRITE;
					end
				end else if (idx_q < occ_q) begin
					rd_en   = 1'b1;
					rd_addr = idx_q[AW-1:0];
					idx_d   = idx_q + OW_ONE;
					pend_d  = 1'b1;
				end else begin
					pend_d = 1'b0;
					if (item_q.op == rmcd_pkg::OP_LOOKUP) begin
						state_d = rmcd_pkg::ST_EVICT_RD;
					end else begin
						status_d = rmcd_pkg::STAT_REL_MISS;
						state_d  = rmcd_pkg::ST_DONE;
					end
				end
			end
			rmcd_pkg::ST_EVICT_RD: begin
				if (evict_ok) begin
					rd_en   = 1'b1;
					rd_addr = occ_m1[AW-1:0];
					state_d = rmcd_pkg::ST_EVICT_CHK;
				end else begin
					state_d = rmcd_pkg::ST_PLACE;
				end
			end
			rmcd_pkg::ST_EVICT_CHK: begin
				if (rd_cnt == CNT_ZERO) begin
					occ_d   = occ_m1;
					evict_d = evict_q + OW_ONE;
					state_d = rmcd_pkg::ST_EVICT_RD;
				end else begin
					state_d = rmcd_pkg::ST_PLACE;
				end
			end
			rmcd_pkg::ST_PLACE: begin
				if (!item_q.create_ok) begin
					status_d = rmcd_pkg::STAT_CREATE_FAIL;
					state_d  = rmcd_pkg::ST_DONE;
				end else if (occ_q == OCC_FULL) begin
					status_d = rmcd_pkg::STAT_FULL;
					state_d  = rmcd_pkg::ST_DONE;
				end else begin
					status_d = rmcd_pkg::STAT_INSERTED;
					cnt_d    = CNT_ONE;
					idx_d    = occ_q;
					pend_d   = 1'b0;
					wpos_d   = '0;
					occ_d    = occ_q + OW_ONE;
					state_d  = rmcd_pkg::ST_SHIFT;
				end
			end
			rmcd_pkg::ST_SHIFT: begin
				if (pend_q) begin
					wr_en   = 1'b1;
					wr_addr = wdst_q;
					wr_data = rd_data;
				end
				if (idx_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = idx_m1[AW-1:0];
					wdst_d  = idx_q[AW-1:0];
					idx_d   = idx_m1;
					pend_d  = 1'b1;
				end else begin
					pend_d  = 1'b0;
					state_d = rmcd_pkg::ST_WRITE;
				end
			end
			rmcd_pkg::ST_WRITE: begin
				wr_en   = 1'b1;
				wr_addr = wpos_q;
				state_d = rmcd_pkg::ST_DONE;
			end
			rmcd_pkg::ST_DONE: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = rmcd_pkg::ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmcd_pkg::ST_IDLE;
			occ_q   <= '0;
			idx_q   <= '0;
			evict_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_d;
			idx_q   <= idx_d;
			evict_q <= evict_d;
			pend_q  <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		item_q   <= item_d;
		status_q <= status_d;
		pos_q    <= pos_d;
		cnt_q    <= cnt_d;
		wpos_q   <= wpos_d;
		wdst_q   <= wdst_d;
	end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int DIR_DEPTH = 16;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;
	localparam logic [1:0] OP_CLEAR_ALT = 2'd3;
	localparam int QUIET_CYCLES = 50;
	localparam int STUCK_LIMIT = 5000;
	localparam int POOL_SIZE = 20;
	localparam int CHUNKS = 8;
	localparam int CHUNK_ITEMS = 214;
	localparam int SMOKE_ROWS = 19;

	typedef struct {
		rmcd_pkg::req_t stim;
		bit             typed;
		rmcd_pkg::rsp_t want;
	} smoke_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	rmcd_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rmcd_pkg::rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [rmcd_pkg::SOFT_W-1:0] cfg_wdata = '0;

	logic [rmcd_pkg::NUM_W-1:0] ent_num [DIR_DEPTH];
	logic [rmcd_pkg::GEN_W-1:0] ent_gen [DIR_DEPTH];
	logic [15:0] ent_cnt [DIR_DEPTH];
	int ent_used = 0;
	logic [rmcd_pkg::SOFT_W-1:0] soft_lim = rmcd_pkg::SOFT_LIMIT_RST;

	rmcd_pkg::rsp_t directory_outcomes [$];
	smoke_row_t smoke_rows [SMOKE_ROWS];
	logic [rmcd_pkg::NUM_W-1:0] pool_num [POOL_SIZE];
	logic [rmcd_pkg::GEN_W-1:0] pool_gen [POOL_SIZE];

	int mismatches = 0;
	int stuck_cycles = 0;
	int req_gap_pct = 0;
	int rsp_stall_pct = 0;
	int rsp_hold_cycles = 0;

	refcounted_mru_cache_directory_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	function automatic int find_entry(logic [rmcd_pkg::NUM_W-1:0] n,
	                                  logic [rmcd_pkg::GEN_W-1:0] g);
		for (int i = 0; i < ent_used; i++)
			if (ent_num[i] == n && ent_gen[i] == g)
				return i;
		return -1;
	endfunction

	function automatic rmcd_pkg::rsp_t predict_directory_op(rmcd_pkg::req_t r);
		rmcd_pkg::rsp_t o;
		int at;
		logic [rmcd_pkg::NUM_W-1:0] kn;
		logic [rmcd_pkg::GEN_W-1:0] kg;
		logic [15:0] kc;
		o = '0;
		if (r.op == rmcd_pkg::OP_LOOKUP) begin
			at = find_entry(r.obj_num, r.obj_gen);
			if (at >= 0) begin
				kn = ent_num[at];
				kg = ent_gen[at];
				kc = ent_cnt[at];
				for (int i = at; i > 0; i--) begin
					ent_num[i] = ent_num[i-1];
					ent_gen[i] = ent_gen[i-1];
					ent_cnt[i] = ent_cnt[i-1];
				end
				if (kc != COUNT_MAX)
					kc = kc + 16'd1;
				ent_num[0] = kn;
				ent_gen[0] = kg;
				ent_cnt[0] = kc;
				o.status = rmcd_pkg::STAT_HIT;
				o.hit_position = 4'(at);
				o.ref_count = kc;
			end else begin
				while (ent_used > 0 && ent_used >= int'(soft_lim) &&
				       ent_cnt[ent_used-1] == 16'd0) begin
					ent_used--;
					o.evicted = o.evicted + 5'd1;
				end
				if (!r.create_ok) begin
					o.status = rmcd_pkg::STAT_CREATE_FAIL;
				end else if (ent_used >= DIR_DEPTH) begin
					o.status = rmcd_pkg::STAT_FULL;
				end else begin
					for (int i = ent_used; i > 0; i--) begin
						ent_num[i] = ent_num[i-1];
						ent_gen[i] = ent_gen[i-1];
						ent_cnt[i] = ent_cnt[i-1];
					end
					ent_num[0] = r.obj_num;
					ent_gen[0] = r.obj_gen;
					ent_cnt[0] = 16'd1;
					ent_used++;
					o.status = rmcd_pkg::STAT_INSERTED;
					o.ref_count = 16'd1;
				end
			end
		end else if (r.op == rmcd_pkg::OP_RELEASE) begin
			at = find_entry(r.obj_num, r.obj_gen);
			if (at >= 0) begin
				if (ent_cnt[at] != 16'd0)
					ent_cnt[at] = ent_cnt[at] - 16'd1;
				o.status = rmcd_pkg::STAT_RELEASED;
				o.hit_position = 4'(at);
				o.ref_count = ent_cnt[at];
			end else begin
				o.status = rmcd_pkg::STAT_REL_MISS;
			end
		end else begin
			ent_used = 0;
			o.status = rmcd_pkg::STAT_CLEARED;
		end
		o.occupancy = 5'(ent_used);
		return o;
	endfunction

	function automatic rmcd_pkg::req_t make_req(logic [1:0] op, logic [rmcd_pkg::NUM_W-1:0] n,
	                                            logic [rmcd_pkg::GEN_W-1:0] g, logic c);
		rmcd_pkg::req_t r;
		r.op = op;
		r.obj_num = n;
		r.obj_gen = g;
		r.create_ok = c;
		return r;
	endfunction

	function automatic logic [rmcd_pkg::NUM_W-1:0] fill_num(int k);
		return rmcd_pkg::NUM_W'(k * 32'h0F0F01 + 32'h000123);
	endfunction

	function automatic logic [rmcd_pkg::GEN_W-1:0] fill_gen(int k);
		return rmcd_pkg::GEN_W'(k * 32'h0301);
	endfunction

	function automatic rmcd_pkg::req_t random_request();
		rmcd_pkg::req_t r;
		int idx;
		int sel;
		idx = $urandom_range(POOL_SIZE - 1);
		r.obj_num = pool_num[idx];
		r.obj_gen = pool_gen[idx];
		if ($urandom_range(99) < 5) begin
			r.obj_num = rmcd_pkg::NUM_W'($urandom);
			r.obj_gen = rmcd_pkg::GEN_W'($urandom);
		end
		r.create_ok = ($urandom_range(9) != 0);
		sel = $urandom_range(199);
		if (sel < 120)
			r.op = rmcd_pkg::OP_LOOKUP;
		else if (sel < 197)
			r.op = rmcd_pkg::OP_RELEASE;
		else
			r.op = ($urandom_range(1) != 0) ? rmcd_pkg::OP_CLEAR : OP_CLEAR_ALT;
		return r;
	endfunction

	task automatic refill_pool();
		for (int i = 0; i < POOL_SIZE; i++) begin
			if (i > 0 && $urandom_range(2) == 0)
				pool_num[i] = pool_num[i-1];
			else
				pool_num[i] = rmcd_pkg::NUM_W'($urandom);
			pool_gen[i] = rmcd_pkg::GEN_W'($urandom);
		end
	endtask

	task automatic offer_request(input rmcd_pkg::req_t r, input bit typed = 1'b0,
	                             input rmcd_pkg::rsp_t want = '0);
		rmcd_pkg::rsp_t predicted;
		while ($urandom_range(99) < req_gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		predicted = predict_directory_op(r);
		directory_outcomes.push_back(typed ? want : predicted);
	endtask

	task automatic wait_quiet();
		req_valid <= 1'b0;
		while (directory_outcomes.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic set_soft_limit(input logic [rmcd_pkg::SOFT_W-1:0] v);
		wait_quiet();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		soft_lim = v;
	endtask

	always @(posedge clk) begin
		if (rsp_hold_cycles > 0) begin
			rsp_ready <= 1'b0;
			rsp_hold_cycles--;
		end else begin
			rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	always @(posedge clk) begin
		rmcd_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (directory_outcomes.size() == 0) begin
				report_mismatch("unexpected result, status", rsp.status, -1);
			end else begin
				want = directory_outcomes.pop_front();
				if (rsp.status !== want.status)
					report_mismatch("status", rsp.status, want.status);
				if (rsp.hit_position !== want.hit_position)
					report_mismatch("hit_position", rsp.hit_position, want.hit_position);
				if (rsp.ref_count !== want.ref_count)
					report_mismatch("ref_count", rsp.ref_count, want.ref_count);
				if (rsp.evicted !== want.evicted)
					report_mismatch("evicted", rsp.evicted, want.evicted);
				if (rsp.occupancy !== want.occupancy)
					report_mismatch("occupancy", rsp.occupancy, want.occupancy);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		smoke_rows = '{
			'{make_req(rmcd_pkg::OP_RELEASE, 24'h000000, 16'h0000, 1'b0), 1'b1,
			  '{rmcd_pkg::STAT_REL_MISS, 4'd0, 16'd0, 5'd0, 5'd0}},
			'{make_req(rmcd_pkg::OP_LOOKUP, 24'h000000, 16'h0000, 1'b0), 1'b1,
			  '{rmcd_pkg::STAT_CREATE_FAIL, 4'd0, 16'd0, 5'd0, 5'd0}},
			'{make_req(rmcd_pkg::OP_LOOKUP, 24'hFFFFFF, 16'hFFFF, 1'b1), 1'b1,
			  '{rmcd_pkg::STAT_INSERTED, 4'd0, 16'd1, 5'd0, 5'd1}},
			'{make_req(rmcd_pkg::OP_LOOKUP, 24'hFFFFFF, 16'hFFFF, 1'b0), 1'b1,
			  '{rmcd_pkg::STAT_HIT, 4'd0, 16'd2, 5'd0, 5'd1}},
			'{make_req(rmcd_pkg::OP_LOOKUP, 24'h000000, 16'h0000, 1'b1), 1'b1,
			  '{rmcd_pkg::STAT_INSERTED, 4'd0, 16'd1, 5'd0, 5'd2}},
			'{make_req(rmcd_pkg::OP_LOOKUP, 24'hFFFFFF, 16'hFFFF, 1'b1), 1'b1,
			  '{rmcd_pkg::STAT_HIT, 4'd1, 16'd3, 5'd0, 5'd2}},
			'{make_req(rmcd_pkg::OP_RELEASE, 24'hFFFFFF, 16'hFFFF, 1'b0), 1'b0, '0},
			'{make_req(rmcd_pkg::OP_RELEASE, 24'hFFFFFF, 16'hFFFF, 1'b1), 1'b0, '0},
			'{make_req(rmcd_pkg::OP_RELEASE, 24'hFFFFFF, 16'hFFFF, 1'b0), 1'b0, '0},
			'{make_req(rmcd_pkg::OP_RELEASE, 24'hFFFFFF, 16'hFFFF, 1'b0), 1'b1,
			  '{rmcd_pkg::STAT_RELEASED, 4'd0, 16'd0, 5'd0, 5'd2}},
			'{make_req(rmcd_pkg::OP_LOOKUP, 24'hFFFFFF, 16'h0000, 1'b1), 1'b0, '0},
			'{make_req(rmcd_pkg::OP_LOOKUP, 24'h000000, 16'hFFFF, 1'b1), 1'b0, '0},
			'{make_req(rmcd_pkg::OP_RELEASE, 24'h000000, 16'hFFFF, 1'b1), 1'b0, '0},
			'{make_req(rmcd_pkg::OP_LOOKUP, 24'h000000, 16'h0000, 1'b1), 1'b0, '0},
			'{make_req(rmcd_pkg::OP_LOOKUP, 24'h555555, 16'hAAAA, 1'b0), 1'b0, '0},
			'{make_req(rmcd_pkg::OP_LOOKUP, 24'hAAAAAA, 16'h5555, 1'b1), 1'b0, '0},
			'{make_req(OP_CLEAR_ALT, 24'hFFFFFF, 16'hFFFF, 1'b1), 1'b1,
			  '{rmcd_pkg::STAT_CLEARED, 4'd0, 16'd0, 5'd0, 5'd0}},
			'{make_req(rmcd_pkg::OP_LOOKUP, 24'h000000, 16'h0000, 1'b1), 1'b1,
			  '{rmcd_pkg::STAT_INSERTED, 4'd0, 16'd1, 5'd0, 5'd1}},
			'{make_req(rmcd_pkg::OP_CLEAR, 24'h000000, 16'h0000, 1'b0), 1'b1,
			  '{rmcd_pkg::STAT_CLEARED, 4'd0, 16'd0, 5'd0, 5'd0}}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < SMOKE_ROWS; i++)
			offer_request(smoke_rows[i].stim, smoke_rows[i].typed, smoke_rows[i].want);

		// Fill to capacity, then walk the full, zero-count and soft-limit extremes.
		for (int k = 0; k < DIR_DEPTH; k++)
			offer_request(make_req(rmcd_pkg::OP_LOOKUP, fill_num(k), fill_gen(k), 1'b1));
		offer_request(make_req(rmcd_pkg::OP_LOOKUP, fill_num(0), fill_gen(0), 1'b0));
		offer_request(make_req(rmcd_pkg::OP_LOOKUP, fill_num(16), fill_gen(16), 1'b1));
		offer_request(make_req(rmcd_pkg::OP_LOOKUP, fill_num(16), fill_gen(16), 1'b0));
		for (int k = 0; k < DIR_DEPTH; k++)
			repeat (3)
				offer_request(make_req(rmcd_pkg::OP_RELEASE, fill_num(k), fill_gen(k), 1'b0));
		set_soft_limit(5'd31);
		offer_request(make_req(rmcd_pkg::OP_LOOKUP, fill_num(16), fill_gen(16), 1'b1));
		set_soft_limit(5'd16);
		offer_request(make_req(rmcd_pkg::OP_LOOKUP, fill_num(17), fill_gen(17), 1'b1));
		offer_request(make_req(rmcd_pkg::OP_RELEASE, fill_num(17), fill_gen(17), 1'b0));
		set_soft_limit(5'd0);
		offer_request(make_req(rmcd_pkg::OP_LOOKUP, fill_num(18), fill_gen(18), 1'b1));

		for (int c = 0; c < CHUNKS; c++) begin
			case (c)
				0: set_soft_limit(5'd1);
				1: set_soft_limit(5'd16);
				2: set_soft_limit(5'd4);
				3: set_soft_limit(5'd0);
				4: set_soft_limit(5'd12);
				5: set_soft_limit(5'd31);
				6: set_soft_limit(5'd2);
				default: set_soft_limit(rmcd_pkg::SOFT_W'($urandom_range(17)));
			endcase
			case (c % 4)
				0: begin
					req_gap_pct = 0;
					rsp_stall_pct = 0;
				end
				1: begin
					req_gap_pct = 74;
					rsp_stall_pct = 0;
				end
				2: begin
					req_gap_pct = 0;
					rsp_stall_pct = 74;
				end
				default: begin
					req_gap_pct = 36;
					rsp_stall_pct = 36;
				end
			endcase
			refill_pool();
			if (c == 0)
				rsp_hold_cycles = 400;
			for (int n = 0; n < CHUNK_ITEMS; n++)
				offer_request(random_request());
		end

		wait_quiet();
		if (directory_outcomes.size() != 0)
			report_mismatch("transactions without a result", directory_outcomes.size(), 0);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
